### src/dns_ptr_query_builder_assert.svh
// Assertion macros for the PTR query builder.
`ifndef DNS_PTR_QUERY_BUILDER_ASSERT_SVH
`define DNS_PTR_QUERY_BUILDER_ASSERT_SVH

// Same-cycle implication.
`define DPQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpq: same-cycle check failed");

// Next-cycle implication.
`define DPQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpq: next-cycle check failed");

`endif

### src/dpq_pkg.sv
`timescale 1ns / 1ps
package dpq_pkg;

   localparam logic [15:0] TID_RESET       = 16'h1204;
   localparam logic [15:0] HDR_FLAGS       = 16'h0100;
   localparam logic [7:0]  QDCOUNT_LOW     = 8'h01;
   localparam logic [7:0]  DIGIT_ZERO      = 8'h30;
   localparam int          HDR_LEN         = 12;
   localparam int          TAIL_LEN        = 18;
   localparam int          QUEUE_DEPTH_DEF = 2;

   // One decimal label: length byte value and three digits (hundreds first).
   typedef struct packed {
      logic [1:0] len;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] ones;
   } label_type;

   // Queue entry: label 0 is built from address bits 7..0.
   typedef struct packed {
      label_type [3:0] lbl;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   function automatic label_type to_label(input logic [7:0] v);
      label_type  res;
      logic [1:0] h;
      logic [7:0] rem;
      logic [14:0] prod;
      logic [7:0] tens_x10;
      h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
      rem = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
      // rem < 100: rem / 10 == (rem * 205) >> 11
      prod = 15'(rem[6:0]) * 15'd205;
      res.hund = {2'b00, h};
      res.tens = prod[14:11];
      tens_x10 = {res.tens, 3'b000} + {3'b000, res.tens, 1'b0};
      res.ones = 4'(rem - tens_x10);
      res.len = (h != 2'd0) ? 2'd3 : ((res.tens != 4'd0) ? 2'd2 : 2'd1);
      return res;
   endfunction

   function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] tid);
      logic [7:0] b;
      case (idx)
         4'd0:    b = tid[15:8];
         4'd1:    b = tid[7:0];
         4'd2:    b = HDR_FLAGS[15:8];
         4'd3:    b = HDR_FLAGS[7:0];
         4'd5:    b = QDCOUNT_LOW;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // "in-addr" "arpa" root, then QTYPE PTR and QCLASS IN.
   function automatic logic [7:0] tail_byte(input logic [4:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = 8'd7;
         5'd1:    b = 8'h69;
         5'd2:    b = 8'h6e;
         5'd3:    b = 8'h2d;
         5'd4:    b = 8'h61;
         5'd5:    b = 8'h64;
         5'd6:    b = 8'h64;
         5'd7:    b = 8'h72;
         5'd8:    b = 8'd4;
         5'd9:    b = 8'h61;
         5'd10:   b = 8'h72;
         5'd11:   b = 8'h70;
         5'd12:   b = 8'h61;
         5'd15:   b = 8'd12;
         5'd17:   b = 8'd1;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### src/dpq_front.sv
`timescale 1ns / 1ps
module dpq_front (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_ipv4_addr,
   input  dpq_pkg::q_status_type q_status,
   output logic                 push,
   output dpq_pkg::entry_type   push_entry
);
   import dpq_pkg::*;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // Labels go out lowest octet first.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         push_entry.lbl[k] = to_label(req_ipv4_addr[8*k +: 8]);
      end
   end

endmodule

### src/dpq_queue.sv
`timescale 1ns / 1ps
module dpq_queue #(
   parameter int DEPTH = dpq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dpq_pkg::entry_type    push_entry,
   input  logic                  pop,
   output dpq_pkg::entry_type    head_entry,
   output dpq_pkg::q_status_type q_status
);
   import dpq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_status.full      = (count_ff == CNT_W'(DEPTH));
   assign q_status.not_empty = (count_ff != '0);
   assign head_entry         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### src/dpq_back.sv
`timescale 1ns / 1ps
module dpq_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           tid,
   input  dpq_pkg::entry_type    head_entry,
   input  dpq_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_msg_byte,
   output logic                  rsp_last_byte
);
   import dpq_pkg::*;

   typedef enum logic [2:0] {
      ST_HDR  = 3'b001,
      ST_LBL  = 3'b010,
      ST_TAIL = 3'b100
   } bk_state_type;

   bk_state_type state_ff, state_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic [1:0]   oct_ff, oct_in;
   logic [1:0]   sub_ff, sub_in;
   logic         valid_ff, valid_in;
   logic [7:0]   byte_ff, byte_in;
   logic         last_ff, last_in;

   logic         out_free;
   logic         adv;
   logic [7:0]   cur_byte;
   logic         cur_last;
   label_type    cur_lbl;
   logic [2:0]   dig_pos;
   logic [3:0]   digit;

   assign out_free = !valid_ff || !rsp_stall;
   assign adv      = q_status.not_empty && out_free;
   assign cur_lbl  = head_entry.lbl[oct_ff];

   // sub 1..len maps onto hundreds/tens/ones skipping leading zeros
   assign dig_pos = 3'(sub_ff) + 3'(2'd3 - cur_lbl.len) - 3'd1;

   always_comb begin
      case (dig_pos[1:0])
         2'd0:    digit = cur_lbl.hund;
         2'd1:    digit = cur_lbl.tens;
         default: digit = cur_lbl.ones;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      oct_in   = oct_ff;
      sub_in   = sub_ff;
      pop      = 1'b0;
      cur_last = 1'b0;
      case (state_ff)
         ST_HDR: begin
            cur_byte = hdr_byte(cnt_ff[3:0], tid);
            if (adv) begin
               if (cnt_ff == 5'(HDR_LEN - 1)) begin
                  state_in = ST_LBL;
                  cnt_in   = '0;
                  oct_in   = '0;
                  sub_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_LBL: begin
            cur_byte = (sub_ff == 2'd0) ? {6'b0, cur_lbl.len} : DIGIT_ZERO + {4'b0, digit};
            if (adv) begin
               if (sub_ff == cur_lbl.len) begin
                  sub_in = '0;
                  if (oct_ff == 2'd3) begin
                     state_in = ST_TAIL;
                     cnt_in   = '0;
                  end else begin
                     oct_in = oct_ff + 1'b1;
                  end
               end else begin
                  sub_in = sub_ff + 1'b1;
               end
            end
         end
         ST_TAIL: begin
            cur_byte = tail_byte(cnt_ff);
            cur_last = (cnt_ff == 5'(TAIL_LEN - 1));
            if (adv) begin
               if (cur_last) begin
                  state_in = ST_HDR;
                  cnt_in   = '0;
                  pop      = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            cur_byte = 8'h00;
            state_in = ST_HDR;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = q_status.not_empty;
      end
      if (adv) begin
         byte_in = cur_byte;
         last_in = cur_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HDR;
         cnt_ff   <= '0;
         oct_ff   <= '0;
         sub_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         oct_ff   <= oct_in;
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_msg_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

### src/dns_ptr_query_builder.sv
`timescale 1ns / 1ps
// Channel | Ports                                   | Moves
// req     | req_valid, req_stall, req_ipv4_addr     | one address per transaction
// rsp     | rsp_valid, rsp_stall, rsp_msg_byte,     | one message byte per transaction
//         | rsp_last_byte                           |
// csr     | csr_wr_en, csr_wr_data                  | transaction id write
//
// Each address gives a 38 to 46 byte message, one byte per cycle while rsp is not
// stalled; the byte sequencer in the back part sets the rate.
// A taken address is written into the queue, then its bytes leave the output register.
// Reset (synchronous, active high) empties the queue, drops the output byte
// and loads the transaction id with 0x1204.
// A stall on rsp freezes the sequencer while an output byte waits; addresses still
// enter until the queue fills, and req_stall is high only while the queue is full.
module dns_ptr_query_builder #(
   parameter int QUEUE_DEPTH = dpq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_ipv4_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_msg_byte,
   output logic        rsp_last_byte,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import dpq_pkg::*;

`include "dns_ptr_query_builder_assert.svh"

   // Transaction id; to be only written while idle (the user's duty, not enforced), so the back part reads it live.
   logic [15:0]  tid_ff, tid_in;

   logic         push;
   logic         pop;
   entry_type    push_entry;
   entry_type    head_entry;
   q_status_type q_status;

   assign tid_in = csr_wr_en ? csr_wr_data : tid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tid_ff <= TID_RESET;
      end else begin
         tid_ff <= tid_in;
      end
   end

   // Front: accept address, split octets into decimal labels.
   dpq_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ipv4_addr (req_ipv4_addr),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   // Short queue decouples label conversion from byte emission.
   dpq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // Back: walk header, labels and suffix one byte per cycle while rsp is not stalled.
   dpq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .tid           (tid_ff),
      .head_entry    (head_entry),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_msg_byte  (rsp_msg_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   // Never write into a full queue, never pop an empty one.
   `DPQ_ASSERT_IMP(a_push_not_full, clock, reset, push, !q_status.full)
   `DPQ_ASSERT_IMP(a_pop_not_empty, clock, reset, pop, q_status.not_empty)
   // Every message ends with the low byte of QCLASS IN.
   `DPQ_ASSERT_IMP(a_last_is_class, clock, reset, rsp_valid && rsp_last_byte, rsp_msg_byte == 8'h01)
   // Retiring an entry (last byte loaded) with no push frees a queue slot.
   `DPQ_ASSERT_NXT(a_pop_frees, clock, reset, pop && !push, !q_status.full)

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import dpq_pkg::*;

   // Clock, reset and run limits
   localparam int CLK_HALF       = 6;        // 12 ns period
   localparam int RESET_CYCLES   = 7;
   localparam int LIMIT_CYCLES   = 800_000;  // several times the slowest legal run
   localparam int DRAIN_CYCLES   = 4;        // bytes pass queue, then output register
   localparam int END_CYCLES     = 50;
   localparam int MAX_IDLE       = 8;
   localparam int LONG_HOLD      = 400;      // receiver hold-off, fills the input queue
   localparam int NUM_PHASES     = 6;
   localparam int ITEMS_PER_PHASE = 60;

   // Wire-format constants of the question tail
   localparam logic [7:0] QTYPE_PTR = 8'd12;
   localparam logic [7:0] QCLASS_IN = 8'd1;

   typedef logic [7:0] byte_q_type[$];

   // One message byte as seen on the rsp channel
   typedef struct packed {
      logic [7:0] msg_byte;
      logic       last_byte;
   } query_byte_type;

   // DUT ports; every input is known from time zero
   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [31:0] req_ipv4_addr = '0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [7:0]  rsp_msg_byte;
   logic        rsp_last_byte;
   logic        csr_wr_en     = 1'b0;
   logic [15:0] csr_wr_data   = '0;

   // Shared state between the stimulus and the response checker
   query_byte_type pending_bytes[$];  // expected message bytes, oldest first
   logic [15:0] model_tid = TID_RESET;
   int          errors = 0;
   bit          tx_no_idle = 1'b0;    // sender offers back to back
   bit          rx_no_idle = 1'b0;    // receiver never stalls on its own
   bit          tx_wait_drain = 1'b0; // sender waits for every byte before next address
   int          rx_hold_request = 0;  // long receiver hold-off, counted by the checker

   // Directed table: address and, where obvious, the expected question name
   // (octets already reversed). An empty name means the predictor decides.
   localparam int N_DIRECTED = 14;
   logic [31:0] dir_addr [N_DIRECTED] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0102_0304, 32'h0A09_6463,
      32'hC8C7_FF00, 32'h7F00_0001, 32'h8000_0000, 32'h0000_0080,
      32'hAAAA_AAAA, 32'h5555_5555, 32'hC0A8_0001, 32'h0B63_6564,
      32'h09C8_0A00, 32'hFE13_EF07
   };
   string dir_name [N_DIRECTED] = '{
      "0.0.0.0", "255.255.255.255", "4.3.2.1", "99.100.9.10",
      "0.255.199.200", "1.0.0.127", "0.0.0.128", "128.0.0.0",
      "170.170.170.170", "85.85.85.85", "", "",
      "", ""
   };

   dns_ptr_query_builder dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ipv4_addr (req_ipv4_addr),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_msg_byte  (rsp_msg_byte),
      .rsp_last_byte (rsp_last_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // Labels from a dotted name: length byte, then the characters.
   function automatic byte_q_type dotted_labels(input string name);
      byte_q_type res;
      int         start;
      start = 0;
      for (int i = 0; i <= name.len(); i++) begin
         if (i == name.len() || name[i] == ".") begin
            res.push_back(8'(i - start));
            for (int j = start; j < i; j++) res.push_back(name[j]);
            start = i + 1;
         end
      end
      return res;
   endfunction

   // Decimal labels of the four octets, low octet first, no leading zeros.
   function automatic byte_q_type decimal_labels(input logic [31:0] addr);
      byte_q_type res;
      int         v;
      for (int k = 0; k < 4; k++) begin
         v = int'(addr[8*k +: 8]);
         if (v >= 100) begin
            res.push_back(8'd3);
            res.push_back(DIGIT_ZERO + 8'(v / 100));
            res.push_back(DIGIT_ZERO + 8'((v % 100) / 10));
            res.push_back(DIGIT_ZERO + 8'(v % 10));
         end else if (v >= 10) begin
            res.push_back(8'd2);
            res.push_back(DIGIT_ZERO + 8'(v / 10));
            res.push_back(DIGIT_ZERO + 8'(v % 10));
         end else begin
            res.push_back(8'd1);
            res.push_back(DIGIT_ZERO + 8'(v));
         end
      end
      return res;
   endfunction

   // Wrap the address labels into a full query and queue its bytes.
   function automatic void queue_ptr_query(input logic [15:0] tid, input byte_q_type labels);
      byte_q_type msg;
      byte_q_type suffix;
      msg = '{tid[15:8], tid[7:0], HDR_FLAGS[15:8], HDR_FLAGS[7:0], 8'h00, QDCOUNT_LOW,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      suffix = dotted_labels("in-addr.arpa");
      msg = {msg, labels, suffix};
      msg.push_back(8'h00);          // root label
      msg.push_back(8'h00);
      msg.push_back(QTYPE_PTR);
      msg.push_back(8'h00);
      msg.push_back(QCLASS_IN);
      foreach (msg[i]) pending_bytes.push_back('{msg[i], (i == msg.size() - 1)});
   endfunction

   // Random address, often with octets right at the label-length boundaries.
   function automatic logic [31:0] random_addr();
      logic [31:0] a;
      logic [7:0]  boundary_octets [8] = '{8'd0, 8'd9, 8'd10, 8'd99,
                                          8'd100, 8'd199, 8'd200, 8'd255};
      a = $urandom;
      if ($urandom_range(0, 2) == 0) begin
         for (int k = 0; k < 4; k++)
            if ($urandom_range(0, 1) == 1) a[8*k +: 8] = boundary_octets[$urandom_range(0, 7)];
      end
      return a;
   endfunction

   // Offer one address and queue its message once the transaction happens.
   // Valid is never lowered and raised within one step.
   task automatic send_query(input logic [31:0] addr, input string name);
      int gap;
      gap = tx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (tx_wait_drain && pending_bytes.size() != 0) begin
         req_valid <= 1'b0;
         while (pending_bytes.size() != 0) @(posedge clock);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_ipv4_addr <= addr;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (name.len() != 0) queue_ptr_query(model_tid, dotted_labels(name));
      else                 queue_ptr_query(model_tid, decimal_labels(addr));
   endtask

   // Register write, only with the block idle.
   task automatic write_transaction_id(input logic [15:0] value);
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_tid   = value;
   endtask

   // Response side: check each transaction against the oldest expected byte,
   // then decide the stall for the next cycle.
   initial begin : rsp_side
      int             stall_left;
      int             hold_left;
      query_byte_type want;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_bytes.size() == 0) begin
               $error("unexpected byte: msg_byte %02h last_byte %0b", rsp_msg_byte,
                      rsp_last_byte);
               errors++;
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_msg_byte !== want.msg_byte) begin
                  $error("msg_byte: expected %02h, got %02h", want.msg_byte, rsp_msg_byte);
                  errors++;
               end
               if (rsp_last_byte !== want.last_byte) begin
                  $error("last_byte: expected %0b, got %0b", want.last_byte, rsp_last_byte);
                  errors++;
               end
            end
            stall_left = rx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (rx_hold_request > 0) begin
            hold_left       = rx_hold_request;
            rx_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on total cycles.
   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("** dns_ptr_query_builder: FAILED **");
      $finish;
   end

   // Stimulus: directed table at the reset id, then random phases, each with
   // its own transaction id; some phases also change the idling pattern.
   initial begin : stimulus
      logic [15:0] tid;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset value of the id, octet zero, label-length boundaries, bit patterns
      for (int i = 0; i < N_DIRECTED; i++) send_query(dir_addr[i], dir_name[i]);
      req_valid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       tid = 16'h0000;
            1:       tid = 16'hFFFF;
            4:       tid = 16'hA55A;
            default: tid = 16'($urandom);
         endcase
         write_transaction_id(tid);
         tx_no_idle    = (p == 1);   // full-rate stretch on both sides
         rx_no_idle    = (p == 1);
         tx_wait_drain = (p == 3);   // one address at a time
         if (p == 2) rx_hold_request = LONG_HOLD;  // queue fills, req_stall rises
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_query(random_addr(), "");
         req_valid <= 1'b0;
      end

      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         $error("%0d expected bytes never arrived", pending_bytes.size());
         errors++;
      end
      if (errors == 0) begin
         $display("** dns_ptr_query_builder: PASSED **");
      end else begin
         $display("** dns_ptr_query_builder: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/dpq_pkg.sv
src/dpq_front.sv
src/dpq_queue.sv
src/dpq_back.sv
src/dns_ptr_query_builder.sv
tb/tb_top.sv
